@@ design/fat_chain_manager_unit_defines.svh @@
// assertion macros for the fat chain manager checker
// no dependencies; included by the port checker file
`ifndef FAT_CHAIN_MANAGER_UNIT_DEFINES_SVH
`define FAT_CHAIN_MANAGER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FCM_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define FCM_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/fcm_pkg.sv @@
// shared types, constants and helpers of the fat chain manager
// no dependencies; used by every module of the block
package fcm_pkg;

	localparam int FAT_ENTRIES = 1024;
	localparam int IDX_W = $clog2(FAT_ENTRIES);
	localparam int STEP_W = IDX_W + 1;
	localparam int ENT_W = 16;
	localparam logic [ENT_W-1:0] END_MARK = 16'hFFFF;

	localparam int SIZE_W = 23;
	localparam int CNT_W = 23;
	localparam int BS_W = 13;
	localparam int DIV_W = SIZE_W + 1;
	localparam int DBIT_W = $clog2(DIV_W);
	localparam int BLOCK_SIZE_RST = 512;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	localparam logic [1:0] KIND_GROW = 2'd0;
	localparam logic [1:0] KIND_SHRINK = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_PAST = 2'd2;

	typedef enum logic [2:0] {
		OP_ECHO,
		OP_PAST,
		OP_GROW_NEW,
		OP_GROW,
		OP_SHRINK_ALL,
		OP_SHRINK,
		OP_LOOKUP
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] first;
		logic             has;
		logic [CNT_W-1:0] cur_n;
		logic [CNT_W-1:0] new_n;
		logic [IDX_W-1:0] tgt;
	} fcm_item_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV_CUR,
		F_DIV_NEW,
		F_PUSH
	} front_st_t;

	typedef enum logic [4:0] {
		B_CLR,
		B_IDLE,
		B_WALK_RD,
		B_WALK_CHK,
		B_LOOP,
		B_SCAN_RD,
		B_SCAN_CHK,
		B_FIRST,
		B_LINK,
		B_MARK,
		B_FREE_RD,
		B_FREE_WR,
		B_CUT_RD,
		B_CUT_CHK,
		B_REST_RD,
		B_REST_WR,
		B_LK_RD,
		B_LK_CHK,
		B_DONE
	} back_st_t;

	// a table value that points at a usable next block
	function automatic logic link_ok(input logic [ENT_W-1:0] v);
		return (v != '0) && (v != END_MARK) && (v < ENT_W'(FAT_ENTRIES));
	endfunction

endpackage

@@ design/fat_chain_manager_unit.sv @@
// top level of the fat chain manager: config register, front, queue and back
// depends on fcm_pkg, fcm_front, fcm_queue, fcm_back
//
// Issue a request by raising start while busy is low; one result per request comes back
// on done for a single cycle, in request order, and must be taken then since the output
// cannot be stalled. After reset the table memory is swept to all free, one entry a cycle,
// and busy stays high for the whole sweep, so no request is taken before it ends. The front
// handles each request with two 24-step bit-serial divisions (ceiling block counts) and a
// hand-off into a two-entry queue, after which it may take the next request while the back
// still works. The back does at most one table read or write per cycle over a single-port
// memory: a read and a check per chain link walked, a read and a write per link freed, a
// read and a check per table entry scanned for a free block (the scan resumes after the
// last block found within one grow) and two writes and a loop per block linked. The worst
// case is a full-table scan plus a long chain. block_size sits at byte address 0 on
// the config port and should only be written while no request is outstanding.
module fat_chain_manager_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// request side
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    kind,
	input  logic [fcm_pkg::IDX_W-1:0]     first_block,
	input  logic                          has_first,
	input  logic [fcm_pkg::SIZE_W-1:0]    current_size,
	input  logic [fcm_pkg::SIZE_W-1:0]    target,
	// result side
	output logic                          done,
	output logic [fcm_pkg::IDX_W-1:0]     first_block_out,
	output logic                          has_first_out,
	output logic [fcm_pkg::IDX_W-1:0]     found_block,
	output logic [1:0]                    status,
	// config port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import fcm_pkg::*;

	logic [BS_W-1:0]  block_size_q;
	logic             cfg_wr;
	logic             start_acc;
	logic             front_busy;
	logic             clearing;
	logic             push;
	fcm_item_t        push_item;
	logic             q_full;
	logic             q_pop;
	fcm_item_t        q_item;
	logic             q_empty;

	// config register, single entry at byte address 0
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? 32'(block_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= BS_W'(BLOCK_SIZE_RST);
		end else if (cfg_wr) begin
			block_size_q <= pwdata[BS_W-1:0];
		end
	end

	// new items are gated by the front being busy and by the table sweep
	assign busy = front_busy || clearing;
	assign start_acc = start && !busy;

	fcm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start_acc    (start_acc),
		.kind         (kind),
		.first_block  (first_block),
		.has_first    (has_first),
		.current_size (current_size),
		.target       (target),
		.block_size   (block_size_q),
		.busy         (front_busy),
		.push         (push),
		.push_item    (push_item),
		.q_full       (q_full)
	);

	fcm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (q_item),
		.empty     (q_empty)
	);

	fcm_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_item          (q_item),
		.q_pop           (q_pop),
		.clearing        (clearing),
		.done            (done),
		.first_block_out (first_block_out),
		.has_first_out   (has_first_out),
		.found_block     (found_block),
		.status          (status)
	);

endmodule

@@ design/fcm_queue.sv @@
// short item queue between the front and back parts
// depends on fcm_pkg
module fcm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fcm_pkg::fcm_item_t push_item,
	output logic              full,
	input  logic              pop,
	output fcm_pkg::fcm_item_t pop_item,
	output logic              empty
);
	import fcm_pkg::*;

	fcm_item_t              ent_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]     wr_ptr_q;
	logic [Q_PTR_W-1:0]     rd_ptr_q;
	logic [Q_PTR_W:0]       cnt_q;

	assign full = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign pop_item = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ design/fcm_front.sv @@
// front part: takes a request, turns byte sizes into block counts, classifies it
// depends on fcm_pkg
module fcm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start_acc,
	input  logic [1:0]                    kind,
	input  logic [fcm_pkg::IDX_W-1:0]     first_block,
	input  logic                          has_first,
	input  logic [fcm_pkg::SIZE_W-1:0]    current_size,
	input  logic [fcm_pkg::SIZE_W-1:0]    target,
	input  logic [fcm_pkg::BS_W-1:0]      block_size,
	output logic                          busy,
	output logic                          push,
	output fcm_pkg::fcm_item_t            push_item,
	input  logic                          q_full
);
	import fcm_pkg::*;

	front_st_t             state_q, state_d;
	logic [1:0]            kind_q;
	logic [IDX_W-1:0]      first_q;
	logic                  has_q;
	logic [SIZE_W-1:0]     tgt_q;
	logic [BS_W-1:0]       bs_q;
	logic [DIV_W-1:0]      num_q;
	logic [BS_W-1:0]       rem_q;
	logic [DIV_W-1:0]      quo_q;
	logic [DBIT_W-1:0]     bit_q;
	logic [CNT_W-1:0]      cur_n_q;
	logic [CNT_W-1:0]      new_n_q;

	logic [BS_W-1:0]       bs_eff;
	logic [BS_W:0]         trial;
	logic                  ge;
	logic [BS_W-1:0]       rem_nx;
	logic [DIV_W-1:0]      quo_nx;
	logic                  last_bit;
	logic                  first_ok;
	logic [CNT_W-1:0]      cur_eff;

	// zero block size acts as one
	assign bs_eff = (block_size == '0) ? BS_W'(1) : block_size;

	// one restoring division bit per cycle
	assign trial = {rem_q, num_q[DIV_W-1]};
	assign ge = (trial >= {1'b0, bs_q});
	assign rem_nx = ge ? BS_W'(trial - {1'b0, bs_q}) : BS_W'(trial);
	assign quo_nx = {quo_q[DIV_W-2:0], ge};
	assign last_bit = (bit_q == DBIT_W'(DIV_W - 1));

	assign busy = (state_q != F_IDLE);
	assign push = (state_q == F_PUSH) && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (start_acc) state_d = F_DIV_CUR;
			end
			F_DIV_CUR: begin
				if (last_bit) state_d = F_DIV_NEW;
			end
			F_DIV_NEW: begin
				if (last_bit) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!q_full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (start_acc) begin
					kind_q <= kind;
					first_q <= first_block;
					has_q <= has_first;
					tgt_q <= target;
					bs_q <= bs_eff;
					num_q <= DIV_W'(current_size) + DIV_W'(bs_eff) - DIV_W'(1);
					rem_q <= '0;
					quo_q <= '0;
					bit_q <= '0;
				end
			end
			F_DIV_CUR, F_DIV_NEW: begin
				if (last_bit && (state_q == F_DIV_CUR)) begin
					// current count done, load the target for the second division
					cur_n_q <= quo_nx[CNT_W-1:0];
					num_q <= DIV_W'(tgt_q) + DIV_W'(bs_q) - DIV_W'(1);
					rem_q <= '0;
					quo_q <= '0;
					bit_q <= '0;
				end else begin
					num_q <= num_q << 1;
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					bit_q <= bit_q + 1'b1;
					if (last_bit) begin
						new_n_q <= quo_nx[CNT_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// classification of the request into a back-end operation
	assign first_ok = has_q && link_ok(ENT_W'(first_q));
	assign cur_eff = has_q ? cur_n_q : '0;

	always_comb begin
		push_item.first = first_q;
		push_item.has = has_q;
		push_item.cur_n = cur_n_q;
		push_item.new_n = new_n_q;
		push_item.tgt = tgt_q[IDX_W-1:0];
		push_item.op = OP_ECHO;
		case (kind_q)
			KIND_GROW: begin
				if ((!has_q || first_ok) && (new_n_q > cur_eff)) begin
					push_item.op = has_q ? OP_GROW : OP_GROW_NEW;
				end
			end
			KIND_SHRINK: begin
				if (first_ok && (new_n_q < cur_n_q)) begin
					push_item.op = (new_n_q == '0) ? OP_SHRINK_ALL : OP_SHRINK;
				end
			end
			KIND_LOOKUP: begin
				if (!first_ok || (tgt_q >= SIZE_W'(FAT_ENTRIES))) begin
					push_item.op = OP_PAST;
				end else begin
					push_item.op = OP_LOOKUP;
				end
			end
			default: push_item.op = OP_ECHO;
		endcase
	end

endmodule

@@ design/fcm_back.sv @@
// back part: walks, links and frees chains in the table memory
// depends on fcm_pkg
module fcm_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	input  fcm_pkg::fcm_item_t        q_item,
	output logic                      q_pop,
	output logic                      clearing,
	output logic                      done,
	output logic [fcm_pkg::IDX_W-1:0] first_block_out,
	output logic                      has_first_out,
	output logic [fcm_pkg::IDX_W-1:0] found_block,
	output logic [1:0]                status
);
	import fcm_pkg::*;

	back_st_t              state_q, state_d;
	logic [ENT_W-1:0]      mem [FAT_ENTRIES];
	logic [ENT_W-1:0]      rdata_q;
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [ENT_W-1:0]      mem_wdata;
	logic                  mem_re;
	logic [IDX_W-1:0]      mem_raddr;

	logic [IDX_W-1:0]      clr_q;
	logic [IDX_W-1:0]      first_q;
	logic                  has_q;
	logic [IDX_W-1:0]      tail_q;
	logic [ENT_W-1:0]      idx_q;
	logic [CNT_W-1:0]      rem_q;
	logic [CNT_W-1:0]      free_q;
	logic [STEP_W-1:0]     steps_q;
	logic [STEP_W-1:0]     scan_q;
	logic [IDX_W-1:0]      f_q;
	logic [1:0]            status_q;
	logic [IDX_W-1:0]      found_q;
	logic                  done_q;
	logic [IDX_W-1:0]      first_out_q;
	logic                  has_out_q;
	logic [IDX_W-1:0]      found_out_q;
	logic [1:0]            status_out_q;

	logic                  rd_ok;
	logic                  steps_max;
	logic                  scan_end;

	assign rd_ok = link_ok(rdata_q);
	assign steps_max = (steps_q == STEP_W'(FAT_ENTRIES));
	assign scan_end = (scan_q == STEP_W'(FAT_ENTRIES));
	assign clearing = (state_q == B_CLR);
	assign q_pop = (state_q == B_IDLE) && !q_empty;

	assign done = done_q;
	assign first_block_out = first_out_q;
	assign has_first_out = has_out_q;
	assign found_block = found_out_q;
	assign status = status_out_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLR;
			clr_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == B_DONE);
			if (state_q == B_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		mem_we = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = END_MARK;
		mem_re = 1'b0;
		mem_raddr = tail_q;
		case (state_q)
			B_CLR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == IDX_W'(FAT_ENTRIES - 1)) state_d = B_IDLE;
			end
			B_IDLE: begin
				if (!q_empty) begin
					case (q_item.op)
						OP_GROW_NEW: state_d = B_SCAN_RD;
						OP_GROW: state_d = B_WALK_RD;
						OP_SHRINK_ALL: state_d = B_FREE_RD;
						OP_SHRINK: state_d = B_CUT_RD;
						OP_LOOKUP: state_d = B_LK_RD;
						default: state_d = B_DONE;
					endcase
				end
			end
			B_WALK_RD: begin
				if (steps_max) begin
					state_d = B_LOOP;
				end else begin
					mem_re = 1'b1;
					state_d = B_WALK_CHK;
				end
			end
			B_WALK_CHK: begin
				state_d = rd_ok ? B_WALK_RD : B_LOOP;
			end
			B_LOOP: begin
				state_d = (rem_q == '0) ? B_DONE : B_SCAN_RD;
			end
			B_SCAN_RD: begin
				if (scan_end) begin
					state_d = B_DONE;
				end else begin
					mem_re = 1'b1;
					mem_raddr = scan_q[IDX_W-1:0];
					state_d = B_SCAN_CHK;
				end
			end
			B_SCAN_CHK: begin
				if (rdata_q == '0) begin
					state_d = has_q ? B_LINK : B_FIRST;
				end else begin
					state_d = B_SCAN_RD;
				end
			end
			B_FIRST: begin
				mem_we = 1'b1;
				mem_waddr = f_q;
				state_d = B_LOOP;
			end
			B_LINK: begin
				mem_we = 1'b1;
				mem_wdata = ENT_W'(f_q);
				state_d = B_MARK;
			end
			B_MARK: begin
				mem_we = 1'b1;
				mem_waddr = f_q;
				state_d = B_LOOP;
			end
			B_FREE_RD: begin
				if ((rem_q == '0) || !link_ok(idx_q) || steps_max) begin
					state_d = B_DONE;
				end else begin
					mem_re = 1'b1;
					mem_raddr = idx_q[IDX_W-1:0];
					state_d = B_FREE_WR;
				end
			end
			B_FREE_WR: begin
				mem_we = 1'b1;
				mem_waddr = idx_q[IDX_W-1:0];
				mem_wdata = '0;
				state_d = B_FREE_RD;
			end
			B_CUT_RD: begin
				if ((rem_q == '0) || steps_max) begin
					state_d = B_REST_RD;
				end else begin
					mem_re = 1'b1;
					state_d = B_CUT_CHK;
				end
			end
			B_CUT_CHK: begin
				state_d = rd_ok ? B_CUT_RD : B_REST_RD;
			end
			B_REST_RD: begin
				mem_re = 1'b1;
				state_d = B_REST_WR;
			end
			B_REST_WR: begin
				mem_we = 1'b1;
				state_d = B_FREE_RD;
			end
			B_LK_RD: begin
				if (rem_q == '0) begin
					state_d = B_DONE;
				end else begin
					mem_re = 1'b1;
					state_d = B_LK_CHK;
				end
			end
			B_LK_CHK: begin
				state_d = rd_ok ? B_LK_RD : B_DONE;
			end
			B_DONE: begin
				state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					// freeing the whole chain leaves the file without a first block
					first_q <= (q_item.op == OP_SHRINK_ALL) ? '0 : q_item.first;
					has_q <= (q_item.op == OP_SHRINK_ALL) ? 1'b0 : q_item.has;
					tail_q <= q_item.first;
					idx_q <= ENT_W'(q_item.first);
					status_q <= (q_item.op == OP_PAST) ? ST_PAST : ST_OK;
					found_q <= '0;
					steps_q <= '0;
					scan_q <= STEP_W'(1);
					free_q <= q_item.cur_n - q_item.new_n;
					case (q_item.op)
						OP_GROW_NEW: rem_q <= q_item.new_n;
						OP_GROW: rem_q <= q_item.new_n - q_item.cur_n;
						OP_SHRINK_ALL: rem_q <= q_item.cur_n;
						OP_SHRINK: rem_q <= q_item.new_n - CNT_W'(1);
						OP_LOOKUP: rem_q <= CNT_W'(q_item.tgt);
						default: rem_q <= '0;
					endcase
				end
			end
			B_WALK_CHK: begin
				if (rd_ok) begin
					tail_q <= rdata_q[IDX_W-1:0];
					steps_q <= steps_q + 1'b1;
				end
			end
			B_SCAN_RD: begin
				if (scan_end) status_q <= ST_FULL;
			end
			B_SCAN_CHK: begin
				scan_q <= scan_q + 1'b1;
				f_q <= scan_q[IDX_W-1:0];
			end
			B_FIRST: begin
				first_q <= f_q;
				has_q <= 1'b1;
				tail_q <= f_q;
				rem_q <= rem_q - 1'b1;
			end
			B_MARK: begin
				tail_q <= f_q;
				rem_q <= rem_q - 1'b1;
			end
			B_FREE_WR: begin
				idx_q <= rdata_q;
				rem_q <= rem_q - 1'b1;
				steps_q <= steps_q + 1'b1;
			end
			B_CUT_CHK: begin
				if (rd_ok) begin
					tail_q <= rdata_q[IDX_W-1:0];
					rem_q <= rem_q - 1'b1;
					steps_q <= steps_q + 1'b1;
				end
			end
			B_REST_WR: begin
				idx_q <= rdata_q;
				rem_q <= free_q;
				steps_q <= '0;
			end
			B_LK_RD: begin
				if (rem_q == '0) found_q <= tail_q;
			end
			B_LK_CHK: begin
				if (rd_ok) begin
					tail_q <= rdata_q[IDX_W-1:0];
					rem_q <= rem_q - 1'b1;
				end else begin
					status_q <= ST_PAST;
				end
			end
			B_DONE: begin
				first_out_q <= has_q ? first_q : '0;
				has_out_q <= has_q;
				found_out_q <= found_q;
				status_out_q <= status_q;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ design/fcm_port_checker.sv @@
// port-level checks for the fat chain manager, bound to the top level
// depends on fcm_pkg and fat_chain_manager_unit_defines.svh
`include "fat_chain_manager_unit_defines.svh"

module fcm_port_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic [fcm_pkg::IDX_W-1:0] first_block_out,
	input logic                      has_first_out,
	input logic [fcm_pkg::IDX_W-1:0] found_block,
	input logic [1:0]                status
);
	import fcm_pkg::*;

	`FCM_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "busy low after accepted item")
	`FCM_ASSERT_IMP(a_status_code, clk, arst_n, done, status == ST_OK || status == ST_FULL || status == ST_PAST, "bad status code")
	`FCM_ASSERT_IMP(a_no_first, clk, arst_n, done && !has_first_out, first_block_out == '0, "first block without chain")
	`FCM_ASSERT_IMP(a_found_ok, clk, arst_n, done && (found_block != '0), status == ST_OK, "found block with error status")

endmodule

bind fat_chain_manager_unit fcm_port_checker u_port_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.first_block_out (first_block_out),
	.has_first_out   (has_first_out),
	.found_block     (found_block),
	.status          (status)
);

@@ verif/testbench.sv @@
// testbench for fat_chain_manager_unit: random and directed chain requests
// depends on fcm_pkg and the design; predicts results with its own table copy
`timescale 1ns / 100ps

typedef struct {
	bit [9:0] first;
	bit       has;
	bit [9:0] found;
	bit [1:0] status;
} fat_result_t;

class fat_scoreboard;
	bit [15:0]   table_copy [1024];
	int unsigned block_bytes;
	fat_result_t expected_q [$];
	int          errors;
	int          mismatches;

	function void clear();
		foreach (table_copy[i]) table_copy[i] = '0;
		block_bytes = fcm_pkg::BLOCK_SIZE_RST;
		errors = 0;
		mismatches = 0;
	endfunction

	function bit usable(int unsigned v);
		return v != 0 && v != 16'hFFFF && v < fcm_pkg::FAT_ENTRIES;
	endfunction

	function int unsigned eff_bytes();
		return block_bytes ? block_bytes : 1;
	endfunction

	function int unsigned blocks_of(int unsigned bytes);
		return (bytes + eff_bytes() - 1) / eff_bytes();
	endfunction

	// first free entry from index 1, 0 when the table is full
	function int unsigned first_free();
		for (int unsigned i = 1; i < fcm_pkg::FAT_ENTRIES; i++)
			if (table_copy[i] == 0) return i;
		return 0;
	endfunction

	function void release_run(int unsigned idx, int unsigned cnt);
		int unsigned nxt;
		int unsigned steps;
		steps = 0;
		while (cnt > 0 && usable(idx) && steps < fcm_pkg::FAT_ENTRIES) begin
			nxt = table_copy[idx];
			table_copy[idx] = 0;
			idx = nxt;
			cnt--;
			steps++;
		end
	endfunction

	function int unsigned chain_len(int unsigned idx);
		int unsigned n;
		n = 1;
		while (usable(table_copy[idx]) && n < fcm_pkg::FAT_ENTRIES) begin
			idx = table_copy[idx];
			n++;
		end
		return n;
	endfunction

	// work out the result of one accepted request and queue it
	function fat_result_t note(bit [1:0] kind, bit [9:0] first_in, bit has_in,
			bit [22:0] cur_size, bit [22:0] tgt);
		fat_result_t r;
		int unsigned first, tail, add, cur_n, new_n, f, last, rest, idx;
		bit has, ok, first_ok;
		first = first_in;
		has = has_in;
		first_ok = has && usable(first);
		r.status = fcm_pkg::ST_OK;
		r.found = 0;
		if (kind == fcm_pkg::KIND_GROW && (!has || first_ok)) begin
			cur_n = has ? blocks_of(cur_size) : 0;
			new_n = blocks_of(tgt);
			if (new_n > cur_n) begin
				add = new_n - cur_n;
				tail = first;
				ok = 1;
				if (!has) begin
					f = first_free();
					if (f == 0) begin
						ok = 0;
						r.status = fcm_pkg::ST_FULL;
					end else begin
						table_copy[f] = 16'hFFFF;
						first = f;
						has = 1;
						tail = f;
						add--;
					end
				end else begin
					for (int s = 0; s < fcm_pkg::FAT_ENTRIES; s++) begin
						if (!usable(table_copy[tail])) break;
						tail = table_copy[tail];
					end
				end
				while (ok && add > 0) begin
					f = first_free();
					if (f == 0) begin
						r.status = fcm_pkg::ST_FULL;
						break;
					end
					table_copy[tail] = 16'(f);
					table_copy[f] = 16'hFFFF;
					tail = f;
					add--;
				end
			end
		end else if (kind == fcm_pkg::KIND_SHRINK && first_ok) begin
			cur_n = blocks_of(cur_size);
			new_n = blocks_of(tgt);
			if (new_n < cur_n) begin
				if (new_n == 0) begin
					release_run(first, cur_n);
					has = 0;
					first = 0;
				end else begin
					last = first;
					for (int unsigned i = 0; i + 1 < new_n && i < fcm_pkg::FAT_ENTRIES; i++) begin
						if (!usable(table_copy[last])) break;
						last = table_copy[last];
					end
					rest = table_copy[last];
					table_copy[last] = 16'hFFFF;
					release_run(rest, cur_n - new_n);
				end
			end
		end else if (kind == fcm_pkg::KIND_LOOKUP) begin
			if (!first_ok || tgt >= fcm_pkg::FAT_ENTRIES) begin
				r.status = fcm_pkg::ST_PAST;
			end else begin
				idx = first;
				for (int unsigned i = 0; i < tgt; i++) begin
					if (!usable(table_copy[idx])) begin
						r.status = fcm_pkg::ST_PAST;
						break;
					end
					idx = table_copy[idx];
				end
				if (r.status == fcm_pkg::ST_OK) r.found = 10'(idx);
			end
		end
		r.first = has ? 10'(first) : 10'd0;
		r.has = has;
		expected_q.push_back(r);
		return r;
	endfunction

	function void check(bit [9:0] first, bit has, bit [9:0] found, bit [1:0] status);
		fat_result_t e;
		if (expected_q.size() == 0) begin
			errors++;
			$display("result with no request outstanding: first %0d", first);
			return;
		end
		e = expected_q.pop_front();
		if (e.first !== first || e.has !== has || e.found !== found || e.status !== status) begin
			errors++;
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp first %0d has %0d found %0d st %0d, got %0d %0d %0d %0d",
					e.first, e.has, e.found, e.status, first, has, found, status);
		end
	endfunction
endclass

module testbench;
	localparam logic [2:0] REG_BLOCK_SIZE = 3'd0;
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;
	localparam int NUM_FILES = 6;
	localparam int MAX_CHAIN = 40;

	typedef struct {
		bit [9:0]    first;
		bit          has;
		int unsigned size;
	} file_rec_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  kind;
	logic [9:0]  first_block;
	logic        has_first;
	logic [22:0] current_size;
	logic [22:0] target;
	logic        done;
	logic [9:0]  first_block_out;
	logic        has_first_out;
	logic [9:0]  found_block;
	logic [1:0]  status;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	fat_scoreboard chains;
	file_rec_t     files [NUM_FILES];
	fat_result_t   last_res;

	fat_chain_manager_unit dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .kind(kind), .first_block(first_block),
		.has_first(has_first), .current_size(current_size), .target(target),
		.done(done), .first_block_out(first_block_out), .has_first_out(has_first_out),
		.found_block(found_block), .status(status),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// generous cap on the run time, sized for the slowest requests
	initial begin
		#40000000;
		$display("Regression FAIL");
		$finish;
	end

	// results are strobed for one cycle; sample mid-cycle to stay clear of the edge
	always @(negedge clk)
		if (arst_n && done)
			chains.check(first_block_out, has_first_out, found_block, status);

	// one item: random gap, then hold start until an edge sees busy low
	task automatic send_req(input logic [1:0] k, input logic [9:0] fb, input logic hf,
			input logic [22:0] cur, input logic [22:0] tgt);
		int gap;
		gap = $urandom_range(0, 13);
		if ($urandom_range(0, 3) == 0) gap = 0; // runs of back-to-back items
		repeat (gap) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		first_block <= fb;
		has_first <= hf;
		current_size <= cur;
		target <= tgt;
		forever begin
			@(negedge clk);
			if (!busy) break;
		end
		@(posedge clk);
		last_res = chains.note(k, fb, hf, cur, tgt);
	endtask

	task automatic drain();
		@(posedge clk);
		start <= 1'b0;
		while (chains.expected_q.size() != 0) @(posedge clk);
	endtask

	// register writes only with nothing in flight; file sizes follow the new block size
	task automatic write_block_size(input logic [31:0] v);
		drain();
		repeat (30) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_BLOCK_SIZE;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		chains.block_bytes = v & 32'h1FFF;
		foreach (files[i])
			files[i].size = files[i].has ?
				chains.chain_len(files[i].first) * chains.eff_bytes() : 0;
	endtask

	// size that lands inside block k, or 0 for no blocks
	function automatic int unsigned bytes_in_block(int unsigned k);
		return k == 0 ? 0 : (k - 1) * chains.eff_bytes() + $urandom_range(1, chains.eff_bytes());
	endfunction

	// well-formed request on one tracked file, with some noise mixed in
	task automatic random_req();
		int fi, r;
		int unsigned nblk, k, tgt, len;
		logic [1:0] op;
		fi = $urandom_range(0, NUM_FILES - 1);
		nblk = chains.blocks_of(files[fi].size);
		r = $urandom_range(0, 99);
		if (r < 70) begin
			if (r < 40) begin
				op = fcm_pkg::KIND_GROW;
				k = nblk + $urandom_range(0, 6);
				if (k > MAX_CHAIN) k = MAX_CHAIN;
			end else begin
				op = fcm_pkg::KIND_SHRINK;
				k = $urandom_range(0, nblk);
			end
			tgt = bytes_in_block(k);
			send_req(op, files[fi].first, files[fi].has, 23'(files[fi].size), 23'(tgt));
			files[fi].first = last_res.first;
			files[fi].has = last_res.has;
			if (!last_res.has) begin
				files[fi].size = 0;
			end else begin
				len = chains.chain_len(last_res.first);
				if (chains.blocks_of(tgt) == len) files[fi].size = tgt;
				else if (chains.blocks_of(files[fi].size) != len)
					files[fi].size = len * chains.eff_bytes();
			end
		end else if (r < 92) begin
			tgt = (r >= 89) ? $urandom_range(0, 8388607) : $urandom_range(0, nblk + 1);
			send_req(fcm_pkg::KIND_LOOKUP, files[fi].first, files[fi].has,
				23'(files[fi].size), 23'(tgt));
		end else begin
			// noise: bad first block on grow and shrink, anything on lookup and unknown kind
			op = 2'($urandom_range(0, 3));
			if (op == fcm_pkg::KIND_GROW || op == fcm_pkg::KIND_SHRINK)
				send_req(op, 10'd0, 1'b1, 23'($urandom_range(0, 8388607)),
					23'($urandom_range(0, 8388607)));
			else
				send_req(op, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
					23'($urandom_range(0, 8388607)), 23'($urandom_range(0, 8388607)));
		end
	endtask

	initial begin
		logic [9:0] head;
		int unsigned bs_list [4];
		chains = new();
		chains.clear();
		foreach (files[i]) files[i] = '{first: 0, has: 0, size: 0};
		arst_n = 1'b0;
		start = 1'b0;
		kind = '0;
		first_block = '0;
		has_first = 1'b0;
		current_size = '0;
		target = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at the reset block size of 512
		send_req(fcm_pkg::KIND_GROW, 10'd0, 1'b0, 23'd0, 23'd1);
		head = last_res.first;
		send_req(fcm_pkg::KIND_GROW, head, 1'b1, 23'd1, 23'd2000);
		send_req(fcm_pkg::KIND_LOOKUP, head, 1'b1, 23'd2000, 23'd0);
		send_req(fcm_pkg::KIND_LOOKUP, head, 1'b1, 23'd2000, 23'd3);
		send_req(fcm_pkg::KIND_LOOKUP, head, 1'b1, 23'd2000, 23'd4);     // past the tail
		send_req(fcm_pkg::KIND_LOOKUP, head, 1'b1, 23'd2000, 23'd1024);  // beyond the table
		send_req(fcm_pkg::KIND_LOOKUP, head, 1'b1, 23'd2000, 23'h7FFFFF);
		send_req(fcm_pkg::KIND_GROW, head, 1'b1, 23'd2000, 23'd1500);    // no growth
		send_req(fcm_pkg::KIND_SHRINK, head, 1'b1, 23'd2000, 23'd2048);  // no cut
		send_req(fcm_pkg::KIND_SHRINK, head, 1'b1, 23'd2000, 23'd600);
		send_req(fcm_pkg::KIND_SHRINK, head, 1'b1, 23'd600, 23'd0);      // frees the whole chain
		send_req(fcm_pkg::KIND_SHRINK, 10'd0, 1'b0, 23'd600, 23'd0);     // file without a chain
		send_req(fcm_pkg::KIND_GROW, 10'd0, 1'b0, 23'd0, 23'd0);         // empty stays empty
		send_req(fcm_pkg::KIND_GROW, 10'd0, 1'b1, 23'd100, 23'd9000);    // bad first block
		send_req(fcm_pkg::KIND_SHRINK, 10'd0, 1'b1, 23'd9000, 23'd1);
		send_req(fcm_pkg::KIND_LOOKUP, 10'd0, 1'b1, 23'd0, 23'd0);
		send_req(fcm_pkg::KIND_LOOKUP, 10'd0, 1'b0, 23'd0, 23'd0);       // no first block
		send_req(KIND_UNKNOWN, 10'h3FF, 1'b1, 23'h7FFFFF, 23'h7FFFFF);
		send_req(fcm_pkg::KIND_LOOKUP, 10'h3FF, 1'b1, 23'd0, 23'd1);     // stale link in free entry

		// fill the whole table at one byte per block, then release it
		write_block_size(32'd1);
		send_req(fcm_pkg::KIND_GROW, 10'd0, 1'b0, 23'd0, 23'd4194304);
		head = last_res.first;
		send_req(fcm_pkg::KIND_GROW, 10'd0, 1'b0, 23'd0, 23'd5);         // not even a first block
		send_req(fcm_pkg::KIND_LOOKUP, head, 1'b1, 23'd1023, 23'd1022);
		send_req(fcm_pkg::KIND_SHRINK, head, 1'b1, 23'd1023, 23'd0);

		// random phases over several block sizes, zero included
		bs_list = '{32'd4096, 32'd0, 32'd512, $urandom_range(1, 4095)};
		foreach (bs_list[p]) begin
			write_block_size(bs_list[p]);
			for (int n = 0; n < 30; n++) begin
				random_req();
				if (p == 1 && n == 15) drain(); // let everything come back before going on
			end
		end
		write_block_size(32'h1FFF & $urandom);
		repeat (6) random_req();

		drain();
		repeat (50) @(posedge clk);
		if (chains.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
